@@ rtl/qdp_pkg.sv @@
`default_nettype none
package qdp_pkg;

    // Block geometry
    localparam int SUB_BLOCK_LEN = 32;
    localparam int PACK_PER_BYTE = 4;
    localparam int ITEMS_PER_SUB = (SUB_BLOCK_LEN + PACK_PER_BYTE - 1) / PACK_PER_BYTE;
    localparam int CNT_W         = (ITEMS_PER_SUB > 1) ? $clog2(ITEMS_PER_SUB) : 1;

    // Field widths
    localparam int CODE_W     = 2;
    localparam int ACT_W      = 8;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = ACT_W + 2;
    localparam int SUB_W      = $clog2(ITEMS_PER_SUB * PACK_PER_BYTE * 256) + 2;
    localparam int SCL_PROD_W = 2 * SCALE_W;
    localparam int TERM_W     = SUB_W + SCL_PROD_W + 1;
    localparam int ACC_W      = 64;

    // Input tdata layout, lowest bit first
    localparam int CODES_LSB  = 0;
    localparam int ACT_LSB    = CODES_LSB + CODE_W * PACK_PER_BYTE;
    localparam int WSCALE_LSB = ACT_LSB + ACT_W * PACK_PER_BYTE;
    localparam int ASCALE_LSB = WSCALE_LSB + SCALE_W;
    localparam int IN_DATA_W  = ASCALE_LSB + SCALE_W;

    // Weight codes: weight = code - 1
    localparam logic [CODE_W-1:0] WCODE_NEG  = 2'd0;
    localparam logic [CODE_W-1:0] WCODE_ZERO = 2'd1;
    localparam logic [CODE_W-1:0] WCODE_ONE  = 2'd2;
    localparam logic [CODE_W-1:0] WCODE_TWO  = 2'd3;

    typedef logic [PACK_PER_BYTE-1:0][PROD_W-1:0] t_prod_vec;

    // Closed sub-block handed from the merge stage to the scale stage
    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic signed [SUB_W-1:0] sum;
        logic [SCL_PROD_W-1:0]   scale;
    } t_sub_tok;

endpackage
`default_nettype wire

@@ rtl/qdp_lane.sv @@
`default_nettype none
module qdp_lane
    import qdp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [CODE_W-1:0]        i_code,
    input  wire logic signed [ACT_W-1:0]  i_act,
    output      logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] w_act_x;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;

    assign w_act_x = PROD_W'(i_act);

    // Weight is -1, 0, 1 or 2: negate, zero, pass or double
    always_comb begin
        case (i_code)
            WCODE_NEG:  n_prod = -w_act_x;
            WCODE_ZERO: n_prod = '0;
            WCODE_ONE:  n_prod = w_act_x;
            WCODE_TWO:  n_prod = w_act_x + w_act_x;
            default:    n_prod = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

@@ rtl/qdp_merge.sv @@
`default_nettype none
module qdp_merge
    import qdp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic                  i_last,
    input  wire t_prod_vec             i_prod,
    input  wire logic [SCL_PROD_W-1:0] i_scale,
    output      t_sub_tok              o_tok
);

    logic signed [SUB_W-1:0] r_sub;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_tok_valid;
    logic                    r_tok_last;
    logic signed [SUB_W-1:0] r_tok_sum;
    logic [SCL_PROD_W-1:0]   r_tok_scale;
    logic signed [SUB_W-1:0] w_item_sum;
    logic signed [SUB_W-1:0] n_sub;
    logic                    w_close;

    // Combine the lane products of one item
    always_comb begin
        w_item_sum = '0;
        for (int k = 0; k < PACK_PER_BYTE; k++) begin
            w_item_sum = w_item_sum + SUB_W'($signed(i_prod[k]));
        end
    end

    assign n_sub   = r_sub + w_item_sum;
    assign w_close = (r_cnt == CNT_W'(ITEMS_PER_SUB - 1)) || i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= '0;
            r_cnt       <= '0;
            r_tok_valid <= 1'b0;
        end else if (i_en) begin
            r_tok_valid <= i_valid && w_close;
            if (i_valid) begin
                if (w_close) begin
                    r_sub <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sub <= n_sub;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok_last  <= i_last;
            r_tok_sum   <= n_sub;
            r_tok_scale <= i_scale;
        end
    end

    assign o_tok = '{valid: r_tok_valid, last: r_tok_last, sum: r_tok_sum,
                     scale: r_tok_scale};

    // A row end always leaves an empty sub-block behind
    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_valid && i_last |=> r_sub == '0 && r_cnt == '0)
        else $error("sub-block state not cleared at row end");

    // Every row end closes a sub-block
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_valid && i_last |=> r_tok_valid && r_tok_last)
        else $error("row end did not close a sub-block");

endmodule
`default_nettype wire

@@ rtl/qdp_scale_acc.sv @@
`default_nettype none
module qdp_scale_acc
    import qdp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_sub_tok                i_tok,
    input  wire logic                    i_m_tready,
    output      logic                    o_stall,
    output      logic                    o_m_tvalid,
    output      logic signed [ACC_W-1:0] o_result,
    output      logic                    o_sat
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic                     r_t_valid;
    logic                     r_t_last;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_clip;
    logic                     r_out_valid;
    logic signed [ACC_W-1:0]  r_out_data;
    logic                     r_out_sat;
    logic signed [ACC_W:0]    w_sum;
    logic                     w_ovf;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     n_clip;

    // Hold everything while a row result is ready and the last word is still waiting
    assign o_stall = r_t_valid && r_t_last && r_out_valid && !i_m_tready;

    // Scale the closed sub-block sum, exact in Q.24
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (i_en) begin
            r_t_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t_last <= i_tok.last;
            r_term   <= i_tok.sum * $signed({1'b0, i_tok.scale});
        end
    end

    // Saturating add into the row accumulator
    assign w_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_term);
    assign w_ovf = w_sum[ACC_W] ^ w_sum[ACC_W-1];

    always_comb begin
        if (w_ovf) begin
            n_acc  = r_term[TERM_W-1] ? ACC_MIN : ACC_MAX;
            n_clip = 1'b1;
        end else begin
            n_acc  = w_sum[ACC_W-1:0];
            n_clip = r_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_en && r_t_valid) begin
                if (r_t_last) begin
                    r_acc       <= '0;
                    r_clip      <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_acc  <= n_acc;
                    r_clip <= n_clip;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_t_valid && r_t_last) begin
            r_out_data <= n_acc;
            r_out_sat  <= n_clip;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out_data;
    assign o_sat      = r_out_sat;

    a_row_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_t_valid && r_t_last |=> r_acc == '0 && !r_clip)
        else $error("row accumulator not cleared after row result");

endmodule
`default_nettype wire

@@ rtl/q2_q8_block_scaled_dot_product.sv @@
`default_nettype none
// Block-scaled 2-bit x 8-bit dot product engine. Each input transaction
// carries one packed byte of four 2-bit weight codes (weight = code - 1),
// four signed 8-bit activations and the two unsigned Q4.12 scales. Four
// lanes form the products in parallel, a merge stage sums them into the
// exact sub-block sum, and every 8 transactions (32 elements) or on tlast
// the sum is multiplied by weight_scale * act_scale and added, with
// saturation, to a signed Q40.24 row accumulator. One result transaction
// leaves per row, on the transaction flagged tlast: tdata is the 64-bit
// row result, tuser[0] is set if the accumulator clipped during the row.
// Throughput is one input transaction per clock while the input is not
// stalled; the pipeline is four registers deep (lanes, merge, scale
// multiply, accumulate), and o_m_axis_tvalid comes from the accumulate
// register. The input stalls only when a row result is finished while
// the previous one is still waiting in the output register.
module q2_q8_block_scaled_dot_product
    import qdp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output      logic                 o_s_axis_tready,
    // weight_codes[7:0], act_0[15:8], act_1[23:16], act_2[31:24],
    // act_3[39:32], weight_scale[55:40], act_scale[71:56]
    input  wire logic [IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                 i_s_axis_tlast,   // row_last
    output      logic                 o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // dot_result[63:0]
    output      logic [ACC_W-1:0]     o_m_axis_tdata,
    // saturated[0]
    output      logic [0:0]           o_m_axis_tuser
);

    logic                    w_en;
    logic                    w_stall;
    logic                    w_accept;
    t_prod_vec               w_prod;
    t_sub_tok                w_tok;
    logic signed [ACC_W-1:0] w_result;
    logic                    w_sat;

    logic                  r_s1_valid;
    logic                  r_s1_last;
    logic [SCL_PROD_W-1:0] r_s1_scale;

    // Advance the whole pipeline unless the accumulate stage must hold
    assign w_en            = !w_stall;
    assign o_s_axis_tready = w_en;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Lanes: one weight code against one activation each
    for (genvar k = 0; k < PACK_PER_BYTE; k++) begin : g_lane
        qdp_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_code (i_s_axis_tdata[CODES_LSB + CODE_W*k +: CODE_W]),
            .i_act  ($signed(i_s_axis_tdata[ACT_LSB + ACT_W*k +: ACT_W])),
            .o_prod (w_prod[k])
        );
    end

    // Stage one control and the combined scale, formed alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_last  <= i_s_axis_tlast;
            r_s1_scale <= SCL_PROD_W'(i_s_axis_tdata[WSCALE_LSB +: SCALE_W])
                        * SCL_PROD_W'(i_s_axis_tdata[ASCALE_LSB +: SCALE_W]);
        end
    end

    // Merge the lanes into the sub-block sum, close sub-blocks
    qdp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1_valid),
        .i_last  (r_s1_last),
        .i_prod  (w_prod),
        .i_scale (r_s1_scale),
        .o_tok   (w_tok)
    );

    // Scale, accumulate with saturation, hold the row result
    qdp_scale_acc u_scale_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_tok      (w_tok),
        .i_m_tready (i_m_axis_tready),
        .o_stall    (w_stall),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_result   (w_result),
        .o_sat      (w_sat)
    );

    assign o_m_axis_tdata    = w_result;
    assign o_m_axis_tuser[0] = w_sat;

    // Input backpressure only ever comes from a blocked row result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
